// File: hw/rtl/ppm_p6_stream_deframer_macros.svh
// Assertion macros shared by the checker of the PPM P6 stream deframer.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef PPM_P6_STREAM_DEFRAMER_MACROS_SVH
`define PPM_P6_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PPMD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PPMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ppmd_pkg.sv
// Shared types and constants of the PPM P6 stream deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppmd_pkg;

	// Default size limit of a parsed dimension, in bits.
	localparam int DIM_BITS_DEF = 12;

	// Fixed widths of the result ports and of the window size registers.
	localparam int DIM_OUT_W = 12;
	localparam int POS_W     = 14;
	localparam int SCREEN_W  = 13;

	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd800;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd600;

	// Entries of the queue between the parser and the result stage.
	localparam int QUEUE_DEPTH = 2;

	// Header syntax bytes.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [8:0] MAXVAL_OK  = 9'd255;
	localparam logic [8:0] MAXVAL_SAT = 9'd511;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_HDR_OK  = 2'd1,
		KIND_HDR_BAD = 2'd2
	} kind_t;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	// One classified request on its way from the parser to the result stage.
	// Positions are kept modulo 2^POS_W; dimensions keep one more bit so that
	// their halves are exact modulo 2^POS_W.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   row;
		logic [POS_W:0]     width;
		logic [POS_W:0]     height;
		logic               last;
	} item_t;

endpackage

`default_nettype wire

// File: hw/rtl/ppmd_front.sv
// Header parser and pixel grouper of the PPM P6 stream deframer.
// Depends on ppmd_pkg; pushes classified requests into ppmd_fifo.
`default_nettype none

module ppmd_front import ppmd_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_of_file,
	input  wire logic       q_full,
	output logic            push,
	output item_t           push_item
);

	localparam int ACC_W = DIM_BITS + 4;

	typedef enum logic [2:0] {
		PH_P, PH_SIX, PH_NL, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_IDLE
	} phase_t;

	phase_t              phase_q, cur_phase, n_phase;
	logic [DIM_BITS-1:0] width_q, height_q, cur_w, cur_h, n_w, n_h;
	logic [DIM_BITS-1:0] col_q, row_q, cur_col, cur_row, n_col, n_row;
	logic [8:0]          maxval_q, cur_mv, n_mv;
	logic [1:0]          comp_q, cur_comp, n_comp;
	logic [7:0]          red_q, green_q, n_red, n_green;
	logic                accept, is_digit, do_push, last_col, last;
	logic [ACC_W-1:0]    dim_acc, dim_sum;
	logic [12:0]         mv_sum;
	logic [DIM_BITS:0]   col_inc, row_inc;
	item_t               item;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A start of file restarts parsing with the byte that carries it.
	always_comb begin
		cur_phase = start_of_file ? PH_P : phase_q;
		cur_w     = start_of_file ? '0 : width_q;
		cur_h     = start_of_file ? '0 : height_q;
		cur_mv    = start_of_file ? '0 : maxval_q;
		cur_col   = start_of_file ? '0 : col_q;
		cur_row   = start_of_file ? '0 : row_q;
		cur_comp  = start_of_file ? '0 : comp_q;
	end

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign dim_acc  = (cur_phase == PH_HEIGHT) ? ACC_W'(cur_h) : ACC_W'(cur_w);
	assign dim_sum  = (dim_acc << 3) + (dim_acc << 1) + ACC_W'(data_byte[3:0]);
	assign mv_sum   = ({4'b0, cur_mv} << 3) + ({4'b0, cur_mv} << 1)
		+ 13'(data_byte[3:0]);
	assign col_inc  = {1'b0, cur_col} + 1'b1;
	assign row_inc  = {1'b0, cur_row} + 1'b1;
	assign last_col = col_inc >= {1'b0, cur_w};
	assign last     = last_col && (row_inc >= {1'b0, cur_h});

	always_comb begin
		n_phase = cur_phase;
		n_w     = cur_w;
		n_h     = cur_h;
		n_mv    = cur_mv;
		n_col   = cur_col;
		n_row   = cur_row;
		n_comp  = cur_comp;
		n_red   = red_q;
		n_green = green_q;
		do_push = 1'b0;
		item         = '0;
		item.kind    = KIND_HDR_BAD;
		item.width   = (POS_W + 1)'(cur_w);
		item.height  = (POS_W + 1)'(cur_h);
		case (cur_phase)
			PH_P: begin
				if (data_byte == CH_P) n_phase = PH_SIX;
				else do_push = 1'b1;
			end
			PH_SIX: begin
				if (data_byte == CH_SIX) n_phase = PH_NL;
				else do_push = 1'b1;
			end
			PH_NL: begin
				if (data_byte == CH_NL) n_phase = PH_WIDTH;
				else do_push = 1'b1;
			end
			PH_WIDTH: begin
				if (is_digit && dim_sum[ACC_W-1:DIM_BITS] == '0) begin
					n_w = dim_sum[DIM_BITS-1:0];
				end else if (!is_digit && data_byte == CH_SPACE && cur_w != '0) begin
					n_phase = PH_HEIGHT;
				end else begin
					do_push = 1'b1;
				end
			end
			PH_HEIGHT: begin
				if (is_digit && dim_sum[ACC_W-1:DIM_BITS] == '0) begin
					n_h = dim_sum[DIM_BITS-1:0];
				end else if (!is_digit && data_byte == CH_NL && cur_h != '0) begin
					n_phase = PH_MAXVAL;
				end else begin
					do_push = 1'b1;
				end
			end
			PH_MAXVAL: begin
				if (is_digit) begin
					n_mv = (mv_sum > 13'(MAXVAL_SAT)) ? MAXVAL_SAT : mv_sum[8:0];
				end else begin
					do_push = 1'b1;
					if (data_byte == CH_NL && cur_mv == MAXVAL_OK) item.kind = KIND_HDR_OK;
				end
			end
			PH_PIXELS: begin
				case (cur_comp)
					2'd0: begin
						n_red  = data_byte;
						n_comp = 2'd1;
					end
					2'd1: begin
						n_green = data_byte;
						n_comp  = 2'd2;
					end
					default: begin
						do_push     = 1'b1;
						item.kind   = KIND_PIXEL;
						item.red    = red_q;
						item.green  = green_q;
						item.blue   = data_byte;
						item.column = POS_W'(cur_col);
						item.row    = POS_W'(cur_row);
						item.last   = last;
						n_comp      = 2'd0;
						if (last) begin
							n_phase = PH_IDLE;
						end else if (last_col) begin
							n_col = '0;
							n_row = row_inc[DIM_BITS-1:0];
						end else begin
							n_col = col_inc[DIM_BITS-1:0];
						end
					end
				endcase
			end
			default: ;
		endcase
		// A header result ends the header either way.
		if (do_push && cur_phase != PH_PIXELS) begin
			n_phase = (item.kind == KIND_HDR_OK) ? PH_PIXELS : PH_IDLE;
		end
	end

	assign push      = accept && do_push;
	assign push_item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_P;
			width_q  <= '0;
			height_q <= '0;
			maxval_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			comp_q   <= '0;
			red_q    <= '0;
			green_q  <= '0;
		end else if (accept) begin
			phase_q  <= n_phase;
			width_q  <= n_w;
			height_q <= n_h;
			maxval_q <= n_mv;
			col_q    <= n_col;
			row_q    <= n_row;
			comp_q   <= n_comp;
			red_q    <= n_red;
			green_q  <= n_green;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ppmd_fifo.sv
// Short request queue between the parser and the result stage.
// Depends on ppmd_pkg for the request type and the queue depth.
`default_nettype none

module ppmd_fifo import ppmd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ppmd_back.sv
// Result stage: computes centred screen positions and holds the output register.
// Depends on ppmd_pkg; drains requests from ppmd_fifo.
`default_nettype none

module ppmd_back import ppmd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire item_t                 q_item,
	output logic                       pop,
	input  wire logic [SCREEN_W-1:0]   screen_width,
	input  wire logic [SCREEN_W-1:0]   screen_height,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 result_kind,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [DIM_OUT_W-1:0]       column,
	output logic [DIM_OUT_W-1:0]       row,
	output logic signed [POS_W-1:0]    screen_x,
	output logic signed [POS_W-1:0]    screen_y,
	output logic [DIM_OUT_W-1:0]       image_width,
	output logic [DIM_OUT_W-1:0]       image_height,
	output logic                       last_pixel
);

	logic             out_valid_q;
	logic [POS_W-1:0] sx, sy;

	assign pop = !q_empty && (!out_valid_q || out_ready);

	// Positions wrap modulo 2^POS_W, so plain unsigned sums give the right bits.
	assign sx = POS_W'(screen_width[SCREEN_W-1:1]) - q_item.width[POS_W:1] + q_item.column;
	assign sy = POS_W'(screen_height[SCREEN_W-1:1]) - q_item.height[POS_W:1] + q_item.row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_kind  <= q_item.kind;
			red          <= q_item.red;
			green        <= q_item.green;
			blue         <= q_item.blue;
			column       <= q_item.column[DIM_OUT_W-1:0];
			row          <= q_item.row[DIM_OUT_W-1:0];
			screen_x     <= (q_item.kind == KIND_PIXEL) ? sx : '0;
			screen_y     <= (q_item.kind == KIND_PIXEL) ? sy : '0;
			image_width  <= q_item.width[DIM_OUT_W-1:0];
			image_height <= q_item.height[DIM_OUT_W-1:0];
			last_pixel   <= q_item.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/ppm_p6_stream_deframer.sv
// A result request goes through the queue, then the output register, to out_valid.
// Throughput: one byte per cycle while in_ready is high; the parser updates its running
// state once per byte and a two-entry queue plus the output register absorb stalls.
// Reset: asynchronous, active low; parsing restarts at the magic, the window size
// returns to 800 by 600 and the queue and output register empty.
// Depends on ppmd_pkg, ppmd_front, ppmd_fifo and ppmd_back.
`default_nettype none

module ppm_p6_stream_deframer import ppmd_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_write,
	input  wire logic                  cfg_index,
	input  wire logic [SCREEN_W-1:0]   cfg_data,
	// Byte input channel.
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  start_of_file,
	// Result channel.
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 result_kind,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [DIM_OUT_W-1:0]       column,
	output logic [DIM_OUT_W-1:0]       row,
	output logic signed [POS_W-1:0]    screen_x,
	output logic signed [POS_W-1:0]    screen_y,
	output logic [DIM_OUT_W-1:0]       image_width,
	output logic [DIM_OUT_W-1:0]       image_height,
	output logic                       last_pixel
);

	// The window size registers. Software must write them only while the block is idle;
	// the block does not enforce it, and the result stage reads them without any hand-off.
	logic [SCREEN_W-1:0] screen_width_q, screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end takes one byte per cycle whenever the queue has room. Each
	// byte either advances the header parser, holds a pixel component, produces a
	// request (a header verdict or a completed pixel), or is dropped when idle.
	logic  q_full, q_empty, q_push, q_pop;
	item_t q_push_item, q_pop_item;

	ppmd_front #(
		.DIM_BITS (DIM_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.q_full        (q_full),
		.push          (q_push),
		.push_item     (q_push_item)
	);

	// The queue lets the parser keep taking bytes while a result waits on
	// the output side, and lets the output drain while bytes are scarce.
	ppmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// The back end centres each pixel in the window and registers the result.
	ppmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_item        (q_pop_item),
		.pop           (q_pop),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.column        (column),
		.row           (row),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.image_width   (image_width),
		.image_height  (image_height),
		.last_pixel    (last_pixel)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ppmd_checker.sv
// Port-level checker of the PPM P6 stream deframer, bound to the top level.
// Depends on ppmd_pkg and the assertion macros header.
`default_nettype none

`include "ppm_p6_stream_deframer_macros.svh"

module ppmd_checker import ppmd_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [1:0]            result_kind,
	input wire logic [7:0]            red,
	input wire logic [7:0]            green,
	input wire logic [7:0]            blue,
	input wire logic [DIM_OUT_W-1:0]  column,
	input wire logic [DIM_OUT_W-1:0]  row,
	input wire logic signed [POS_W-1:0] screen_x,
	input wire logic signed [POS_W-1:0] screen_y,
	input wire logic [DIM_OUT_W-1:0]  image_width,
	input wire logic [DIM_OUT_W-1:0]  image_height,
	input wire logic                  last_pixel
);

	// A stalled result keeps its kind, column, row, screen_x and last flag.
	`PPMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(column) && $stable(row) && $stable(screen_x) && $stable(last_pixel), "result changed while stalled")

	// A header verdict carries no pixel content.
	`PPMD_ASSERT(a_hdr_clean, out_valid && result_kind != KIND_PIXEL, red == 8'd0 && green == 8'd0 && blue == 8'd0 && column == '0 && row == '0 && screen_x == '0 && screen_y == '0 && !last_pixel, "header result with pixel content")

	// The final pixel sits in the bottom right corner of the image.
	`PPMD_ASSERT(a_last_corner, out_valid && result_kind == KIND_PIXEL && last_pixel, column == DIM_OUT_W'(image_width - 1'b1) && row == DIM_OUT_W'(image_height - 1'b1), "last pixel not at the image corner")

endmodule

bind ppm_p6_stream_deframer ppmd_checker u_checker (.*);

`default_nettype wire
